>>> src/amab_pkg.sv
`default_nettype none

package amab_pkg;

	// Queue and protocol constants
	localparam int unsigned QUEUE_DEPTH    = 16;
	localparam int unsigned MAX_BACKOFFS   = 4;
	localparam logic [7:0]  BROADCAST_ADDR = 8'hFF;

	localparam int unsigned QPTR_W     = $clog2(QUEUE_DEPTH);
	localparam int unsigned QCNT_W     = $clog2(QUEUE_DEPTH + 1);
	localparam int unsigned BCNT_W     = 4;
	localparam int unsigned CFG_IDX_W  = 3;
	localparam int unsigned CFG_DATA_W = 16;

	typedef logic [QPTR_W-1:0] qptr_t;
	typedef logic [QCNT_W-1:0] qcnt_t;
	typedef logic [BCNT_W-1:0] bcnt_t;

	localparam qptr_t QPTR_LAST  = qptr_t'(QUEUE_DEPTH - 1);
	localparam qcnt_t QCNT_FULL  = qcnt_t'(QUEUE_DEPTH);
	localparam bcnt_t BCNT_LIMIT = bcnt_t'(MAX_BACKOFFS);

	// Event codes
	typedef enum logic [2:0] {
		FN_ENQUEUE      = 3'd0,
		FN_BACKOFF_DONE = 3'd1,
		FN_WAIT_DONE    = 3'd2,
		FN_TX_DONE      = 3'd3,
		FN_RX_ACK       = 3'd4,
		FN_RX_DATA      = 3'd5,
		FN_ACK_RETRY    = 3'd6
	} func_t;

	// Transceiver states
	typedef enum logic [1:0] {
		RADIO_SLEEP     = 2'd0,
		RADIO_IDLE      = 2'd1,
		RADIO_SENDING   = 2'd2,
		RADIO_RECEIVING = 2'd3
	} radio_t;

	// Head frame completion codes
	typedef enum logic [1:0] {
		HD_NONE      = 2'd0,
		HD_COMPLETED = 2'd1,
		HD_DROPPED   = 2'd2
	} head_done_t;

	// Configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_ACK_ON            = 3'd0,
		CFG_PERSIST_THRESHOLD = 3'd1,
		CFG_MIN_BACKOFF_TICKS = 3'd2,
		CFG_MAX_BACKOFF_TICKS = 3'd3,
		CFG_WAIT_ACK_TICKS    = 3'd4,
		CFG_ACK_RETRY_MAX     = 3'd5,
		CFG_OWN_ADDRESS       = 3'd6
	} cfg_idx_t;

	// MAC mode, one-hot
	typedef enum logic [3:0] {
		MODE_PASSIVE  = 4'b0001,
		MODE_BACKOFF  = 4'b0010,
		MODE_SEND     = 4'b0100,
		MODE_WAIT_ACK = 4'b1000
	} mode_t;

	typedef struct packed {
		logic [2:0]  func;
		logic [7:0]  dest_address;
		logic [7:0]  src_address;
		logic        rx_error;
		logic [1:0]  radio_state;
		logic [15:0] rand_persist;
		logic [15:0] rand_delay;
	} evt_t;

	typedef struct packed {
		logic        tx_data;
		logic [7:0]  data_dest;
		logic        send_ack;
		logic [7:0]  ack_dest;
		logic        backoff_start;
		logic [15:0] backoff_ticks;
		logic        wait_ack_start;
		logic        ack_retry_start;
		logic [15:0] ack_retry_ticks;
		logic        deliver_up;
		logic [1:0]  head_done;
		logic        request_rejected;
	} res_t;

	typedef struct packed {
		logic        ack_on;
		logic [15:0] persist_threshold;
		logic [15:0] min_backoff_ticks;
		logic [15:0] max_backoff_ticks;
		logic [15:0] ack_retry_max;
		logic [7:0]  own_address;
	} cfg_t;

	// Control from the decision stage to the destination queue
	typedef struct packed {
		logic       we;
		qptr_t      waddr;
		logic [7:0] wdata;
		logic       rd_en;
		qptr_t      raddr0;
		qptr_t      raddr1;
	} qreq_t;

	// Head entry and the one behind it
	typedef struct packed {
		logic [7:0] head0;
		logic [7:0] head1;
	} qdata_t;

	function automatic qptr_t qptr_inc(input qptr_t p);
		return (p == QPTR_LAST) ? '0 : p + 1'b1;
	endfunction

endpackage

`default_nettype wire

>>> src/amab_dq.sv
`default_nettype none

module amab_dq (
	input  wire logic             clk,
	input  amab_pkg::qreq_t       req,
	output amab_pkg::qdata_t      rdata
);

	logic [7:0] mem_q [amab_pkg::QUEUE_DEPTH];
	logic [7:0] rd0_s1, rd1_s1, fwd_data_s1;
	logic       fwd0_s1, fwd1_s1;

	// Write the tail entry; read the next two head entries for the incoming request
	always_ff @(posedge clk) begin
		if (req.we) begin
			mem_q[req.waddr] <= req.wdata;
		end
		if (req.rd_en) begin
			rd0_s1      <= mem_q[req.raddr0];
			rd1_s1      <= mem_q[req.raddr1];
			fwd0_s1     <= req.we && (req.waddr == req.raddr0);
			fwd1_s1     <= req.we && (req.waddr == req.raddr1);
			fwd_data_s1 <= req.wdata;
		end
	end

	// Forward an entry written in the same cycle as it was read
	assign rdata.head0 = fwd0_s1 ? fwd_data_s1 : rd0_s1;
	assign rdata.head1 = fwd1_s1 ? fwd_data_s1 : rd1_s1;

endmodule

`default_nettype wire

>>> src/amab_core.sv
`default_nettype none

module amab_core (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  amab_pkg::cfg_t        cfg,
	input  amab_pkg::evt_t        evt,
	input  wire logic             fire,
	input  wire logic             accept,
	input  amab_pkg::qdata_t      qdata,
	output amab_pkg::qreq_t       qreq,
	output amab_pkg::res_t        res
);

	amab_pkg::mode_t mode_q, mode_d;
	amab_pkg::bcnt_t bcnt_q, bcnt_d;
	logic            blk_q, blk_d;
	logic            last_ack_q, last_ack_d;
	amab_pkg::qptr_t head_q, head_d, tail_q, tail_d, raddr;
	amab_pkg::qcnt_t cnt_q, cnt_d;

	logic        busy, use_retry, is_bcast, for_us;
	logic [15:0] lo, hi, mul_a, bo_ticks;
	logic [31:0] prod;
	logic [7:0]  hd;

	assign busy     = (evt.radio_state == amab_pkg::RADIO_SENDING) ||
	                  (evt.radio_state == amab_pkg::RADIO_RECEIVING);
	assign is_bcast = (evt.dest_address == amab_pkg::BROADCAST_ADDR);
	assign for_us   = (evt.dest_address == cfg.own_address);

	// Share one multiplier between the backoff span and the ACK retry delay
	always_comb begin
		use_retry = (amab_pkg::func_t'(evt.func) == amab_pkg::FN_ACK_RETRY) ||
		            ((amab_pkg::func_t'(evt.func) == amab_pkg::FN_RX_DATA) &&
		             cfg.ack_on && !is_bcast);
		if (cfg.max_backoff_ticks < cfg.min_backoff_ticks) begin
			lo = cfg.max_backoff_ticks;
			hi = cfg.min_backoff_ticks;
		end else begin
			lo = cfg.min_backoff_ticks;
			hi = cfg.max_backoff_ticks;
		end
		mul_a    = use_retry ? cfg.ack_retry_max : (hi - lo);
		prod     = {16'd0, mul_a} * {16'd0, evt.rand_delay};
		bo_ticks = lo + prod[31:16];
	end

	// Decide the result and the next state for the request in the stage
	always_comb begin
		logic q_we, do_tsh, removed, ack_req, bo_req;
		mode_d     = mode_q;
		bcnt_d     = bcnt_q;
		blk_d      = blk_q;
		last_ack_d = last_ack_q;
		head_d     = head_q;
		tail_d     = tail_q;
		cnt_d      = cnt_q;
		res        = '0;
		q_we       = 1'b0;
		do_tsh     = 1'b0;
		removed    = 1'b0;
		ack_req    = 1'b0;
		bo_req     = 1'b0;
		hd         = removed ? qdata.head1 : qdata.head0;

		unique case (amab_pkg::func_t'(evt.func))
			amab_pkg::FN_ENQUEUE: begin
				if (cnt_q == amab_pkg::QCNT_FULL) begin
					res.request_rejected = 1'b1;
				end else begin
					q_we   = 1'b1;
					tail_d = amab_pkg::qptr_inc(tail_q);
					cnt_d  = cnt_q + 1'b1;
					do_tsh = (mode_q == amab_pkg::MODE_PASSIVE) && (cnt_q == '0) && !blk_q;
				end
			end
			amab_pkg::FN_BACKOFF_DONE: begin
				do_tsh = 1'b1;
			end
			amab_pkg::FN_WAIT_DONE: begin
				bcnt_d = bcnt_q + 1'b1;
				if (bcnt_d < amab_pkg::BCNT_LIMIT) begin
					bo_req = 1'b1;
				end else begin
					// give up on the head frame
					bcnt_d        = '0;
					res.head_done = amab_pkg::HD_DROPPED;
					if (cnt_q != '0) begin
						head_d  = amab_pkg::qptr_inc(head_q);
						cnt_d   = cnt_q - 1'b1;
						removed = 1'b1;
					end
					mode_d = amab_pkg::MODE_PASSIVE;
					do_tsh = !blk_q && (cnt_d != '0);
				end
			end
			amab_pkg::FN_TX_DONE: begin
				if (blk_q) begin
					blk_d  = 1'b0;
					do_tsh = (mode_q == amab_pkg::MODE_PASSIVE) && (cnt_q != '0);
				end else if (!cfg.ack_on) begin
					mode_d = amab_pkg::MODE_PASSIVE;
					do_tsh = (cnt_q != '0);
				end else if (!last_ack_q) begin
					mode_d = amab_pkg::MODE_WAIT_ACK;
				end
			end
			amab_pkg::FN_RX_ACK: begin
				if (!evt.rx_error && for_us && (mode_q == amab_pkg::MODE_WAIT_ACK)) begin
					bcnt_d        = '0;
					res.head_done = amab_pkg::HD_COMPLETED;
					if (cnt_q != '0) begin
						head_d  = amab_pkg::qptr_inc(head_q);
						cnt_d   = cnt_q - 1'b1;
						removed = 1'b1;
					end
					mode_d = amab_pkg::MODE_PASSIVE;
					do_tsh = !blk_q && (cnt_d != '0);
				end
			end
			amab_pkg::FN_RX_DATA: begin
				if (!evt.rx_error && (for_us || is_bcast)) begin
					res.deliver_up = 1'b1;
					if (cfg.ack_on && !is_bcast) begin
						ack_req = 1'b1;
						bcnt_d  = '0;
					end else begin
						do_tsh = (mode_q == amab_pkg::MODE_PASSIVE) && !blk_q && (cnt_q != '0);
					end
				end
			end
			amab_pkg::FN_ACK_RETRY: begin
				ack_req = 1'b1;
			end
			default: begin
			end
		endcase

		// Offer an ACK, or schedule its retry when the radio is busy
		if (ack_req) begin
			res.ack_dest = evt.src_address;
			if (busy) begin
				res.ack_retry_start = 1'b1;
				res.ack_retry_ticks = prod[31:16];
				mode_d              = amab_pkg::MODE_PASSIVE;
			end else begin
				res.send_ack = 1'b1;
				last_ack_d   = 1'b1;
				blk_d        = 1'b1;
			end
		end

		// Offer the head frame with p-persistence
		if (evt.func == amab_pkg::FN_ENQUEUE) begin
			hd = evt.dest_address;
		end else begin
			hd = removed ? qdata.head1 : qdata.head0;
		end
		if (do_tsh) begin
			if (cnt_d == '0) begin
				mode_d = amab_pkg::MODE_PASSIVE;
			end else if (evt.rand_persist <= cfg.persist_threshold) begin
				if (busy) begin
					mode_d = amab_pkg::MODE_PASSIVE;
				end else begin
					if ((hd != amab_pkg::BROADCAST_ADDR) && cfg.ack_on) begin
						mode_d             = amab_pkg::MODE_WAIT_ACK;
						res.wait_ack_start = 1'b1;
					end else begin
						if (res.head_done == amab_pkg::HD_NONE) begin
							res.head_done = amab_pkg::HD_COMPLETED;
						end
						head_d = amab_pkg::qptr_inc(head_d);
						cnt_d  = cnt_d - 1'b1;
						mode_d = amab_pkg::MODE_PASSIVE;
					end
					res.tx_data   = 1'b1;
					res.data_dest = hd;
					last_ack_d    = 1'b0;
					blk_d         = 1'b1;
				end
			end else begin
				// failed draw: the count stays below its limit here, so always back off
				bo_req = 1'b1;
			end
		end

		// Start the backoff timer
		if (bo_req) begin
			mode_d            = amab_pkg::MODE_BACKOFF;
			res.backoff_start = 1'b1;
			res.backoff_ticks = bo_ticks;
		end

		qreq.we    = fire && q_we;
		qreq.waddr = tail_q;
		qreq.wdata = evt.dest_address;

		// Read the head entries for the next request as they stand after this one
		raddr       = fire ? head_d : head_q;
		qreq.rd_en  = accept;
		qreq.raddr0 = raddr;
		qreq.raddr1 = amab_pkg::qptr_inc(raddr);
	end

	// Advance the MAC state as the request leaves the stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q     <= amab_pkg::MODE_PASSIVE;
			bcnt_q     <= '0;
			blk_q      <= 1'b0;
			last_ack_q <= 1'b0;
			head_q     <= '0;
			tail_q     <= '0;
			cnt_q      <= '0;
		end else if (fire) begin
			mode_q     <= mode_d;
			bcnt_q     <= bcnt_d;
			blk_q      <= blk_d;
			last_ack_q <= last_ack_d;
			head_q     <= head_d;
			tail_q     <= tail_d;
			cnt_q      <= cnt_d;
		end
	end

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= amab_pkg::QCNT_FULL)
		else $error("queue count above depth");

	a_bcnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		bcnt_q < amab_pkg::BCNT_LIMIT)
		else $error("backoff count reached its limit");

	a_ptr_meet: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q == '0 || cnt_q == amab_pkg::QCNT_FULL) |-> head_q == tail_q)
		else $error("queue pointers disagree with count");

	a_drop_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && res.head_done == amab_pkg::HD_DROPPED) |=> bcnt_q == '0)
		else $error("backoff count not cleared after drop");

endmodule

`default_nettype wire

>>> src/aloha_mac_ack_backoff.sv
// ALOHA MAC controller with ACKs and random backoff. One event request is
// taken per cycle while the result output is not stalled, and its result is
// presented from the output register after the decision stage: the request
// is registered together with the two leading entries of the destination
// queue (a 16-entry memory with one write and two registered read ports,
// same-cycle writes forwarded), decided in one stage with a single shared
// 16x16 multiplier for the delay draws, and held in an output register that
// lets the next request enter while a result waits. Each event produces
// exactly one result. Configuration writes are always taken and should be
// made only while no request is in flight; ACK wait time writes are not stored.
`default_nettype none

module aloha_mac_ack_backoff (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	input  wire logic                                  evt_valid,
	output logic                                       evt_ready,
	input  amab_pkg::evt_t                             evt,
	output logic                                       res_valid,
	input  wire logic                                  res_ready,
	output amab_pkg::res_t                             res,
	input  wire logic                                  cfg_valid,
	output logic                                       cfg_ready,
	input  wire logic [amab_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  wire logic [amab_pkg::CFG_DATA_W-1:0]       cfg_data
);

	amab_pkg::cfg_t   cfg_q;
	amab_pkg::evt_t   evt_s1;
	amab_pkg::res_t   res_d, res_q;
	amab_pkg::qreq_t  qreq;
	amab_pkg::qdata_t qdata;
	logic             valid_s1, out_valid_q, s1_fire, evt_acc;

	// Handshake: the stage moves on when the output register is free or emptying
	assign s1_fire   = valid_s1 && (!out_valid_q || res_ready);
	assign evt_ready = !valid_s1 || s1_fire;
	assign evt_acc   = evt_valid && evt_ready;
	assign cfg_ready = 1'b1;
	assign res_valid = out_valid_q;
	assign res       = res_q;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.ack_on            <= 1'b1;
			cfg_q.persist_threshold <= 16'hFFFF;
			cfg_q.min_backoff_ticks <= 16'd0;
			cfg_q.max_backoff_ticks <= 16'd1500;
			cfg_q.ack_retry_max     <= 16'd50;
			cfg_q.own_address       <= 8'd0;
		end else if (cfg_valid) begin
			unique case (amab_pkg::cfg_idx_t'(cfg_index))
				amab_pkg::CFG_ACK_ON:            cfg_q.ack_on            <= cfg_data[0];
				amab_pkg::CFG_PERSIST_THRESHOLD: cfg_q.persist_threshold <= cfg_data;
				amab_pkg::CFG_MIN_BACKOFF_TICKS: cfg_q.min_backoff_ticks <= cfg_data;
				amab_pkg::CFG_MAX_BACKOFF_TICKS: cfg_q.max_backoff_ticks <= cfg_data;
				amab_pkg::CFG_WAIT_ACK_TICKS: begin
				end
				amab_pkg::CFG_ACK_RETRY_MAX:     cfg_q.ack_retry_max     <= cfg_data;
				amab_pkg::CFG_OWN_ADDRESS:       cfg_q.own_address       <= cfg_data[7:0];
				default: begin
				end
			endcase
		end
	end

	// Decision stage valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (evt_acc) begin
			valid_s1 <= 1'b1;
		end else if (s1_fire) begin
			valid_s1 <= 1'b0;
		end
	end

	// Hold the request payload in the stage
	always_ff @(posedge clk) begin
		if (evt_acc) begin
			evt_s1 <= evt;
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_fire) begin
			out_valid_q <= 1'b1;
		end else if (res_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_fire) begin
			res_q <= res_d;
		end
	end

	amab_dq u_dq (
		.clk   (clk),
		.req   (qreq),
		.rdata (qdata)
	);

	amab_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_q),
		.evt    (evt_s1),
		.fire   (s1_fire),
		.accept (evt_acc),
		.qdata  (qdata),
		.qreq   (qreq),
		.res    (res_d)
	);

	a_fire_shows: assert property (@(posedge clk) disable iff (!arst_n)
		s1_fire |=> res_valid)
		else $error("decided request not presented");

endmodule

`default_nettype wire

>>> tb/tb_aloha_mac_ack_backoff.sv
module tb_aloha_mac_ack_backoff;
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [2:0]  FN_UNKNOWN      = 3'd7;
	localparam int unsigned PHASES          = 6;
	localparam int unsigned ITEMS_PER_PHASE = 250;
	localparam int unsigned STALL_LIMIT     = 2000;
	localparam int unsigned SETTLE_CYCLES   = 4;
	localparam int unsigned TAIL_CYCLES     = 10;
	localparam int unsigned REPORT_MAX      = 10;

	typedef struct {
		amab_pkg::evt_t ev;
		int unsigned    rep;
		logic           typed;
		amab_pkg::res_t want;
	} stim_row_t;

	typedef struct {
		logic        ack_on;
		logic [15:0] persist;
		logic [15:0] bo_min;
		logic [15:0] bo_max;
		logic [15:0] wait_ticks;
		logic [15:0] retry_max;
		logic [7:0]  own;
	} reg_set_t;

	logic           clk = 1'b0;
	logic           arst_n = 1'b0;
	logic           evt_valid = 1'b0;
	logic           evt_ready;
	amab_pkg::evt_t evt = '0;
	logic           res_valid;
	logic           res_ready = 1'b0;
	amab_pkg::res_t res;
	logic           cfg_valid = 1'b0;
	logic           cfg_ready;
	logic [2:0]     cfg_index = '0;
	logic [15:0]    cfg_data = '0;

	aloha_mac_ack_backoff dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.evt_valid (evt_valid),
		.evt_ready (evt_ready),
		.evt       (evt),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Shadow state of the MAC
	amab_pkg::cfg_t  mac_cfg;
	amab_pkg::mode_t mac_mode;
	amab_pkg::bcnt_t bo_count;
	logic            radio_held;
	logic            sent_ack_last;
	logic [7:0]      dq_mem [amab_pkg::QUEUE_DEPTH];
	amab_pkg::qptr_t dq_head;
	amab_pkg::qptr_t dq_tail;
	amab_pkg::qcnt_t dq_count;

	// Per-request inputs seen by the decision helpers
	logic           cur_busy;
	logic [15:0]    cur_rp;
	logic [15:0]    cur_rd;
	amab_pkg::res_t pr;

	amab_pkg::res_t pending_results [$];
	stim_row_t      dir_rows [$];
	reg_set_t       phase_regs [PHASES];

	int unsigned send_idle_pct = 0;
	int unsigned recv_stall_pct = 0;
	int unsigned burst_left = 0;
	int unsigned mismatch_count = 0;
	int unsigned error_count = 0;
	int unsigned idle_cycles = 0;

	function automatic amab_pkg::qptr_t next_slot(input amab_pkg::qptr_t p);
		return (p == amab_pkg::QPTR_LAST) ? amab_pkg::qptr_t'(0) : amab_pkg::qptr_t'(p + 1'b1);
	endfunction

	// Report the first removal only; pop only when something is queued
	function automatic void remove_head(input amab_pkg::head_done_t code);
		if (pr.head_done == amab_pkg::HD_NONE)
			pr.head_done = code;
		if (dq_count > 0) begin
			dq_head  = next_slot(dq_head);
			dq_count = dq_count - 1'b1;
		end
	endfunction

	function automatic void offer_ack(input logic [7:0] dest);
		logic [31:0] prod;
		pr.ack_dest = dest;
		if (cur_busy) begin
			prod = 32'(mac_cfg.ack_retry_max) * 32'(cur_rd);
			pr.ack_retry_start = 1'b1;
			pr.ack_retry_ticks = prod[31:16];
			mac_mode = amab_pkg::MODE_PASSIVE;
		end else begin
			pr.send_ack   = 1'b1;
			sent_ack_last = 1'b1;
			radio_held    = 1'b1;
		end
	endfunction

	function automatic void start_backoff(input logic counted);
		logic [15:0] lo;
		logic [15:0] hi;
		logic [31:0] span;
		if (counted)
			bo_count = bo_count + 1'b1;
		if (bo_count < amab_pkg::BCNT_LIMIT) begin
			lo = mac_cfg.min_backoff_ticks;
			hi = mac_cfg.max_backoff_ticks;
			if (hi < lo) begin
				lo = mac_cfg.max_backoff_ticks;
				hi = mac_cfg.min_backoff_ticks;
			end
			span = 32'(hi - lo) * 32'(cur_rd);
			mac_mode         = amab_pkg::MODE_BACKOFF;
			pr.backoff_start = 1'b1;
			pr.backoff_ticks = lo + span[31:16];
		end else begin
			// give up on the head frame, then offer the next one
			bo_count = '0;
			remove_head(amab_pkg::HD_DROPPED);
			mac_mode = amab_pkg::MODE_PASSIVE;
			resume_if_free();
		end
	endfunction

	function automatic void offer_head();
		logic [7:0] dest;
		if (dq_count == 0) begin
			mac_mode = amab_pkg::MODE_PASSIVE;
			return;
		end
		mac_mode = amab_pkg::MODE_SEND;
		if (cur_rp > mac_cfg.persist_threshold) begin
			start_backoff(1'b0);
		end else if (cur_busy) begin
			// frame stays queued
			mac_mode = amab_pkg::MODE_PASSIVE;
		end else begin
			dest = dq_mem[dq_head];
			if (dest != amab_pkg::BROADCAST_ADDR && mac_cfg.ack_on) begin
				mac_mode          = amab_pkg::MODE_WAIT_ACK;
				pr.wait_ack_start = 1'b1;
			end else begin
				remove_head(amab_pkg::HD_COMPLETED);
				mac_mode = amab_pkg::MODE_PASSIVE;
			end
			pr.tx_data    = 1'b1;
			pr.data_dest  = dest;
			sent_ack_last = 1'b0;
			radio_held    = 1'b1;
		end
	endfunction

	function automatic void resume_if_free();
		if (mac_mode == amab_pkg::MODE_PASSIVE && !radio_held && dq_count > 0)
			offer_head();
	endfunction

	// Advance the shadow state by one request and return its result
	function automatic amab_pkg::res_t predict_mac_result(input amab_pkg::evt_t ev);
		pr       = '0;
		cur_busy = (ev.radio_state == amab_pkg::RADIO_SENDING)
			|| (ev.radio_state == amab_pkg::RADIO_RECEIVING);
		cur_rp   = ev.rand_persist;
		cur_rd   = ev.rand_delay;
		case (ev.func)
			amab_pkg::FN_ENQUEUE: begin
				if (dq_count >= amab_pkg::QCNT_FULL) begin
					pr.request_rejected = 1'b1;
				end else begin
					dq_mem[dq_tail] = ev.dest_address;
					dq_tail  = next_slot(dq_tail);
					dq_count = dq_count + 1'b1;
					if (mac_mode == amab_pkg::MODE_PASSIVE && dq_count == 1 && !radio_held)
						offer_head();
				end
			end
			amab_pkg::FN_BACKOFF_DONE: offer_head();
			amab_pkg::FN_WAIT_DONE: start_backoff(1'b1);
			amab_pkg::FN_TX_DONE: begin
				if (radio_held) begin
					radio_held = 1'b0;
					resume_if_free();
				end else if (!mac_cfg.ack_on) begin
					mac_mode = amab_pkg::MODE_PASSIVE;
					resume_if_free();
				end else if (!sent_ack_last) begin
					mac_mode = amab_pkg::MODE_WAIT_ACK;
				end
			end
			amab_pkg::FN_RX_ACK: begin
				if (!ev.rx_error && ev.dest_address == mac_cfg.own_address
						&& mac_mode == amab_pkg::MODE_WAIT_ACK) begin
					bo_count = '0;
					remove_head(amab_pkg::HD_COMPLETED);
					mac_mode = amab_pkg::MODE_PASSIVE;
					resume_if_free();
				end
			end
			amab_pkg::FN_RX_DATA: begin
				if (!ev.rx_error && (ev.dest_address == mac_cfg.own_address
						|| ev.dest_address == amab_pkg::BROADCAST_ADDR)) begin
					pr.deliver_up = 1'b1;
					if (mac_cfg.ack_on && ev.dest_address != amab_pkg::BROADCAST_ADDR) begin
						offer_ack(ev.src_address);
						bo_count = '0;
					end else begin
						resume_if_free();
					end
				end
			end
			amab_pkg::FN_ACK_RETRY: offer_ack(ev.src_address);
			default: ;
		endcase
		return pr;
	endfunction

	function automatic amab_pkg::evt_t mk_evt(input logic [2:0] func, input logic [7:0] dst,
			input logic [7:0] src, input logic err, input logic [1:0] radio,
			input logic [15:0] rp, input logic [15:0] rd);
		amab_pkg::evt_t ev;
		ev.func         = func;
		ev.dest_address = dst;
		ev.src_address  = src;
		ev.rx_error     = err;
		ev.radio_state  = radio;
		ev.rand_persist = rp;
		ev.rand_delay   = rd;
		return ev;
	endfunction

	function automatic void add_row(input amab_pkg::evt_t ev, input int unsigned rep,
			input logic typed, input amab_pkg::res_t want);
		dir_rows.push_back('{ev, rep, typed, want});
	endfunction

	// Mostly follow the protocol from the current state, with noise and bursts
	function automatic amab_pkg::evt_t draw_event();
		amab_pkg::evt_t ev;
		ev.dest_address = 8'($urandom);
		ev.src_address  = 8'($urandom);
		ev.rx_error     = ($urandom_range(9) == 0);
		case ($urandom_range(7))
			0:       ev.radio_state = amab_pkg::RADIO_RECEIVING;
			1:       ev.radio_state = amab_pkg::RADIO_SENDING;
			2, 3:    ev.radio_state = amab_pkg::RADIO_SLEEP;
			default: ev.radio_state = amab_pkg::RADIO_IDLE;
		endcase
		if ($urandom_range(3) == 0)
			ev.rand_persist = 16'($urandom);
		else
			ev.rand_persist = 16'($urandom_range(mac_cfg.persist_threshold, 0));
		case ($urandom_range(9))
			0:       ev.rand_delay = 16'h0000;
			1:       ev.rand_delay = 16'hFFFF;
			default: ev.rand_delay = 16'($urandom);
		endcase
		if (burst_left > 0) begin
			burst_left--;
			ev.func = amab_pkg::FN_ENQUEUE;
		end else if ($urandom_range(99) < 2) begin
			burst_left = 17;
			ev.func = amab_pkg::FN_ENQUEUE;
		end else if ($urandom_range(9) < 7) begin
			if (radio_held)
				ev.func = amab_pkg::FN_TX_DONE;
			else if (mac_mode == amab_pkg::MODE_BACKOFF)
				ev.func = amab_pkg::FN_BACKOFF_DONE;
			else if (mac_mode == amab_pkg::MODE_WAIT_ACK)
				ev.func = ($urandom_range(4) < 3) ? amab_pkg::FN_RX_ACK
					: amab_pkg::FN_WAIT_DONE;
			else
				ev.func = $urandom_range(1) ? amab_pkg::FN_ENQUEUE : amab_pkg::FN_RX_DATA;
		end else begin
			ev.func = 3'($urandom_range(7));
		end
		case (ev.func)
			amab_pkg::FN_RX_ACK:
				if ($urandom_range(9) < 7)
					ev.dest_address = mac_cfg.own_address;
			amab_pkg::FN_RX_DATA:
				case ($urandom_range(9))
					0, 1, 2, 3: ev.dest_address = mac_cfg.own_address;
					4, 5, 6:    ev.dest_address = amab_pkg::BROADCAST_ADDR;
					default:    ;
				endcase
			amab_pkg::FN_ENQUEUE:
				if ($urandom_range(3) == 0)
					ev.dest_address = amab_pkg::BROADCAST_ADDR;
			default: ;
		endcase
		return ev;
	endfunction

	// Present one request, hold it until taken, then log what it should yield
	task automatic send_event(input amab_pkg::evt_t ev, input logic typed,
			input amab_pkg::res_t want);
		amab_pkg::res_t pred;
		@(negedge clk);
		while ($urandom_range(99) < send_idle_pct) begin
			evt_valid <= 1'b0;
			@(negedge clk);
		end
		evt_valid <= 1'b1;
		evt       <= ev;
		do @(posedge clk); while (!evt_ready);
		pred = predict_mac_result(ev);
		pending_results.push_back(typed ? want : pred);
	endtask

	task automatic write_reg(input amab_pkg::cfg_idx_t idx, input logic [15:0] value);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			amab_pkg::CFG_ACK_ON:            mac_cfg.ack_on            = value[0];
			amab_pkg::CFG_PERSIST_THRESHOLD: mac_cfg.persist_threshold = value;
			amab_pkg::CFG_MIN_BACKOFF_TICKS: mac_cfg.min_backoff_ticks = value;
			amab_pkg::CFG_MAX_BACKOFF_TICKS: mac_cfg.max_backoff_ticks = value;
			amab_pkg::CFG_ACK_RETRY_MAX:     mac_cfg.ack_retry_max     = value;
			amab_pkg::CFG_OWN_ADDRESS:       mac_cfg.own_address       = value[7:0];
			default: ;
		endcase
	endtask

	task automatic load_regs(input reg_set_t s);
		write_reg(amab_pkg::CFG_ACK_ON, 16'(s.ack_on));
		write_reg(amab_pkg::CFG_PERSIST_THRESHOLD, s.persist);
		write_reg(amab_pkg::CFG_MIN_BACKOFF_TICKS, s.bo_min);
		write_reg(amab_pkg::CFG_MAX_BACKOFF_TICKS, s.bo_max);
		write_reg(amab_pkg::CFG_WAIT_ACK_TICKS, s.wait_ticks);
		write_reg(amab_pkg::CFG_ACK_RETRY_MAX, s.retry_max);
		write_reg(amab_pkg::CFG_OWN_ADDRESS, 16'(s.own));
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// Stop sending and let every outstanding result come back
	task automatic drain();
		@(negedge clk);
		evt_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Randomise result back-pressure
	always @(negedge clk)
		res_ready <= ($urandom_range(99) >= recv_stall_pct);

	// Compare each delivered result with the oldest expectation
	always @(posedge clk) begin
		amab_pkg::res_t want;
		if (arst_n && res_valid && res_ready) begin
			if (pending_results.size() == 0) begin
				error_count++;
				if (mismatch_count < REPORT_MAX)
					$display("unexpected result %p", res);
				mismatch_count++;
			end else begin
				want = pending_results.pop_front();
				if (res.tx_data !== want.tx_data || res.data_dest !== want.data_dest
						|| res.send_ack !== want.send_ack
						|| res.ack_dest !== want.ack_dest
						|| res.backoff_start !== want.backoff_start
						|| res.backoff_ticks !== want.backoff_ticks
						|| res.wait_ack_start !== want.wait_ack_start
						|| res.ack_retry_start !== want.ack_retry_start
						|| res.ack_retry_ticks !== want.ack_retry_ticks
						|| res.deliver_up !== want.deliver_up
						|| res.head_done !== want.head_done
						|| res.request_rejected !== want.request_rejected) begin
					error_count++;
					if (mismatch_count < REPORT_MAX)
						$display("mismatch: expected %p got %p", want, res);
					mismatch_count++;
				end
			end
		end
	end

	// Abort when no channel moves for too long
	always @(posedge clk) begin
		if ((evt_valid && evt_ready) || (res_valid && res_ready) || (cfg_valid && cfg_ready))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("[aloha_mac_ack_backoff] ERROR");
			$finish;
		end
	end

	initial begin
		amab_pkg::res_t r;
		amab_pkg::evt_t ev;

		mac_cfg = '{ack_on: 1'b1, persist_threshold: 16'd65535, min_backoff_ticks: 16'd0,
			max_backoff_ticks: 16'd1500, ack_retry_max: 16'd50, own_address: 8'd0};
		mac_mode      = amab_pkg::MODE_PASSIVE;
		bo_count      = '0;
		radio_held    = 1'b0;
		sent_ack_last = 1'b0;
		dq_head       = '0;
		dq_tail       = '0;
		dq_count      = '0;
		for (int i = 0; i < amab_pkg::QUEUE_DEPTH; i++)
			dq_mem[i] = '0;

		phase_regs[0] = '{1'b1, 16'd65535, 16'd0, 16'd1500, 16'd100, 16'd50, 8'd0};
		phase_regs[1] = '{1'b0, 16'd40000, 16'd200, 16'd100, 16'd0, 16'd65535, 8'd254};
		phase_regs[2] = '{1'b1, 16'd0, 16'd65535, 16'd65535, 16'd65535, 16'd0, 8'd17};
		phase_regs[3] = '{1'b1, 16'd30000, 16'd0, 16'd65535, 16'd100, 16'd1000, 8'd254};
		phase_regs[4] = '{1'b0, 16'd65535, 16'd0, 16'd0, 16'd1, 16'd7, 8'd0};
		phase_regs[5] = '{1'b1, 16'd50000, 16'd1000, 16'd3000, 16'd250, 16'd50, 8'd128};

		// Directed rows, register values as after reset
		r = '0;
		add_row(mk_evt(FN_UNKNOWN, 8'hFF, 8'hFF, 1'b1, amab_pkg::RADIO_IDLE, 16'hFFFF,
			16'hFFFF), 1, 1'b1, r);
		r = '0; r.tx_data = 1'b1; r.data_dest = 8'h12; r.wait_ack_start = 1'b1;
		add_row(mk_evt(amab_pkg::FN_ENQUEUE, 8'h12, 8'h00, 1'b0, amab_pkg::RADIO_IDLE,
			16'h0000, 16'h0000), 1, 1'b1, r);
		r = '0;
		add_row(mk_evt(amab_pkg::FN_TX_DONE, 8'h00, 8'h00, 1'b0, amab_pkg::RADIO_IDLE,
			16'h0000, 16'h0000), 1, 1'b1, r);
		r = '0; r.head_done = amab_pkg::HD_COMPLETED;
		add_row(mk_evt(amab_pkg::FN_RX_ACK, 8'h00, 8'h44, 1'b0, amab_pkg::RADIO_IDLE,
			16'h0000, 16'h0000), 1, 1'b1, r);
		r = '0; r.deliver_up = 1'b1;
		add_row(mk_evt(amab_pkg::FN_RX_DATA, amab_pkg::BROADCAST_ADDR, 8'h33, 1'b0,
			amab_pkg::RADIO_IDLE, 16'h0, 16'h0), 1, 1'b1, r);
		// ACK meets a busy radio: retry after the longest draw
		r = '0; r.deliver_up = 1'b1; r.ack_dest = 8'hAB; r.ack_retry_start = 1'b1;
		r.ack_retry_ticks = 16'd49;
		add_row(mk_evt(amab_pkg::FN_RX_DATA, 8'h00, 8'hAB, 1'b0, amab_pkg::RADIO_SENDING,
			16'h0, 16'hFFFF), 1, 1'b1, r);
		r = '0; r.send_ack = 1'b1; r.ack_dest = 8'hAB;
		add_row(mk_evt(amab_pkg::FN_ACK_RETRY, 8'h00, 8'hAB, 1'b0, amab_pkg::RADIO_IDLE,
			16'h0, 16'h0), 1, 1'b1, r);
		r = '0;
		add_row(mk_evt(amab_pkg::FN_RX_DATA, 8'h00, 8'h01, 1'b1, amab_pkg::RADIO_IDLE,
			16'h0, 16'h0), 1, 1'b1, r);
		add_row(mk_evt(amab_pkg::FN_ENQUEUE, amab_pkg::BROADCAST_ADDR, 8'h00, 1'b0,
			amab_pkg::RADIO_IDLE, 16'h0, 16'h0), 1, 1'b1, r);
		r = '0; r.tx_data = 1'b1; r.data_dest = amab_pkg::BROADCAST_ADDR;
		r.head_done = amab_pkg::HD_COMPLETED;
		add_row(mk_evt(amab_pkg::FN_TX_DONE, 8'h00, 8'h00, 1'b0, amab_pkg::RADIO_IDLE,
			16'hFFFF, 16'h0), 1, 1'b1, r);
		// Fill the queue while the radio is held, then overflow it
		add_row(mk_evt(amab_pkg::FN_ENQUEUE, 8'h00, 8'h00, 1'b0, amab_pkg::RADIO_IDLE,
			16'h0, 16'h0), 8, 1'b0, r);
		add_row(mk_evt(amab_pkg::FN_ENQUEUE, 8'h5A, 8'h00, 1'b0, amab_pkg::RADIO_IDLE,
			16'h0, 16'h0), 8, 1'b0, r);
		r = '0; r.request_rejected = 1'b1;
		add_row(mk_evt(amab_pkg::FN_ENQUEUE, 8'h77, 8'h00, 1'b0, amab_pkg::RADIO_IDLE,
			16'h0, 16'h0), 1, 1'b1, r);
		r = '0; r.backoff_start = 1'b1; r.backoff_ticks = 16'd0;
		add_row(mk_evt(amab_pkg::FN_WAIT_DONE, 8'h00, 8'h00, 1'b0, amab_pkg::RADIO_IDLE,
			16'h0, 16'h0000), 1, 1'b1, r);
		r = '0; r.backoff_start = 1'b1; r.backoff_ticks = 16'd1499;
		add_row(mk_evt(amab_pkg::FN_WAIT_DONE, 8'h00, 8'h00, 1'b0, amab_pkg::RADIO_IDLE,
			16'h0, 16'hFFFF), 1, 1'b1, r);
		// Third backoff, then the give-up drop
		add_row(mk_evt(amab_pkg::FN_WAIT_DONE, 8'h00, 8'h00, 1'b0, amab_pkg::RADIO_IDLE,
			16'h0, 16'h8000), 2, 1'b0, r);
		add_row(mk_evt(amab_pkg::FN_TX_DONE, 8'h00, 8'h00, 1'b0, amab_pkg::RADIO_IDLE,
			16'hFFFF, 16'h0), 1, 1'b0, r);
		// ACKs that are corrupted or not for this node
		add_row(mk_evt(amab_pkg::FN_RX_ACK, 8'h00, 8'h00, 1'b1, amab_pkg::RADIO_IDLE,
			16'h0, 16'h0), 1, 1'b0, r);
		add_row(mk_evt(amab_pkg::FN_RX_ACK, 8'h01, 8'h00, 1'b0, amab_pkg::RADIO_IDLE,
			16'h0, 16'h0), 1, 1'b0, r);
		add_row(mk_evt(amab_pkg::FN_TX_DONE, 8'h00, 8'h00, 1'b0, amab_pkg::RADIO_IDLE,
			16'h0, 16'h0), 1, 1'b0, r);
		add_row(mk_evt(amab_pkg::FN_RX_ACK, 8'h00, 8'h00, 1'b0, amab_pkg::RADIO_IDLE,
			16'hFFFF, 16'h0), 1, 1'b0, r);
		add_row(mk_evt(amab_pkg::FN_TX_DONE, 8'h00, 8'h00, 1'b0, amab_pkg::RADIO_SLEEP,
			16'h0, 16'h0), 1, 1'b0, r);
		add_row(mk_evt(amab_pkg::FN_WAIT_DONE, 8'h00, 8'h00, 1'b0, amab_pkg::RADIO_IDLE,
			16'h0, 16'h1234), 1, 1'b0, r);
		// Data frame offered into a busy radio stays queued
		add_row(mk_evt(amab_pkg::FN_BACKOFF_DONE, 8'h00, 8'h00, 1'b0,
			amab_pkg::RADIO_RECEIVING, 16'h0, 16'h0), 1, 1'b0, r);
		add_row(mk_evt(amab_pkg::FN_ACK_RETRY, 8'h00, 8'hFF, 1'b0, amab_pkg::RADIO_SLEEP,
			16'h0, 16'h0), 1, 1'b0, r);
		add_row(mk_evt(amab_pkg::FN_RX_DATA, 8'h00, 8'h00, 1'b0, amab_pkg::RADIO_IDLE,
			16'h0, 16'h0), 1, 1'b0, r);
		add_row(mk_evt(amab_pkg::FN_TX_DONE, 8'h00, 8'h00, 1'b0, amab_pkg::RADIO_IDLE,
			16'h0, 16'h0), 1, 1'b0, r);

		// Hold reset, then release it on a falling edge
		arst_n = 1'b0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		send_idle_pct  = 22;
		recv_stall_pct = 53;
		foreach (dir_rows[i])
			for (int k = 0; k < dir_rows[i].rep; k++)
				send_event(dir_rows[i].ev, dir_rows[i].typed, dir_rows[i].want);
		drain();

		for (int p = 0; p < PHASES; p++) begin
			case (p / 2)
				0: begin send_idle_pct = 22; recv_stall_pct = 53; end
				1: begin send_idle_pct = 53; recv_stall_pct = 22; end
				default: begin send_idle_pct = 0; recv_stall_pct = 0; end
			endcase
			load_regs(phase_regs[p]);
			burst_left = 0;
			for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
				ev = draw_event();
				send_event(ev, 1'b0, '0);
			end
			drain();
		end

		repeat (TAIL_CYCLES) @(posedge clk);
		if (pending_results.size() != 0)
			error_count++;
		if (error_count == 0)
			$display("[aloha_mac_ack_backoff] OK");
		else
			$display("[aloha_mac_ack_backoff] ERROR");
		$finish;
	end

endmodule
